>>> src/ray_plane_intersection_macros.svh
// ----------------------------------------------------------------------------
// Ray-plane intersection assertion macros
// Concurrent assertion helpers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef RAY_PLANE_INTERSECTION_MACROS_SVH
`define RAY_PLANE_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RPI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ray_plane_intersection: assertion failed");
// next-cycle implication
`define RPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ray_plane_intersection: assertion failed");
`else
`define RPI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RPI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg
// Widths, register codes and inter-stage types of the ray-plane block.
// ----------------------------------------------------------------------------
package rpi_pkg;

   localparam int COORD_W           = 32;
   localparam int THR_W             = 17;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int DEFAULT_FRAC_BITS = 16;

   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_N_W = DIFF_W + COORD_W;
   localparam int PROD_D_W = 2 * COORD_W;
   localparam int NUM_W    = PROD_N_W + 2;
   localparam int DEN_W    = PROD_D_W + 2;
   // |num| < 2^65 and |den| <= 3 * 2^62
   localparam int MAG_N_W  = NUM_W - 1;
   localparam int MAG_D_W  = DEN_W - 2;
   localparam int QUO_W    = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_Z   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_X  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_Y  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_Z  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 3'd6;

   localparam logic [COORD_W-1:0] NORMAL_Z_RESET  = 32'h0001_0000;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 17'd7;
   localparam logic [QUO_W-1:0]   DIST_MAX        = '1;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] point;
      logic [2:0][COORD_W-1:0] normal;
      logic [THR_W-1:0]        threshold;
   } cfg_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] origin;
      logic [2:0][COORD_W-1:0] dir;
   } ray_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } dot_type;

   typedef struct packed {
      logic [MAG_N_W-1:0] n_mag;
      logic [MAG_D_W-1:0] d_mag;
      logic               hit;
      logic               sat;
   } cls_type;

   typedef struct packed {
      logic             hit;
      logic             sat;
      logic [QUO_W-1:0] quo;
   } div_type;

endpackage

>>> src/ray_plane_intersection.sv
// Throughput: one request per clock cycle, sustained, with no stall on the response side.
// A request passes five stages of dot products and tests, 31 divider stages and
//   one output register before its response is valid.
// The 31-stage restoring divider, one quotient bit per stage, sets the latency.
// Reset is synchronous and active high: it empties every stage and loads the
//   register defaults (normal = +z, threshold = 7); no clearing pass follows.
// ----------------------------------------------------------------------------
// ray_plane_intersection
// Distance along a ray to a configured plane, signed fixed point in, unsigned out.
// ----------------------------------------------------------------------------
`include "ray_plane_intersection_macros.svh"

module ray_plane_intersection #(
   parameter int FRAC_BITS = rpi_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_write,
   input  logic        [rpi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [rpi_pkg::CSR_DATA_W-1:0]  csr_data,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rpi_pkg::COORD_W-1:0]     req_origin_x,
   input  logic signed [rpi_pkg::COORD_W-1:0]     req_origin_y,
   input  logic signed [rpi_pkg::COORD_W-1:0]     req_origin_z,
   input  logic signed [rpi_pkg::COORD_W-1:0]     req_dir_x,
   input  logic signed [rpi_pkg::COORD_W-1:0]     req_dir_y,
   input  logic signed [rpi_pkg::COORD_W-1:0]     req_dir_z,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   output logic        [rpi_pkg::QUO_W-1:0]       rsp_distance
);
   import rpi_pkg::*;

   cfg_type          cfg_ff;
   ray_type          ray;

   logic             dot_in_ready;
   logic             dot_valid;
   logic             cls_in_ready;
   dot_type          dot;
   logic             cls_valid;
   logic             div_in_ready;
   cls_type          cls;
   logic             div_valid;
   div_type          div;

   logic             out_open;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_hit_ff;
   logic [QUO_W-1:0] rsp_distance_ff;
   logic [QUO_W-1:0] distance_in;

   // ---------------------------------------------------------------------
   // Configuration registers, read directly by the stages. Writes must land only
   // while the pipe is idle; the block does not check. Drop writes to unknown indexes.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point     <= '0;
         cfg_ff.normal    <= {NORMAL_Z_RESET, COORD_W'(0), COORD_W'(0)};
         cfg_ff.threshold <= THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POINT_X:   cfg_ff.point[0]  <= csr_data[COORD_W-1:0];
            CSR_POINT_Y:   cfg_ff.point[1]  <= csr_data[COORD_W-1:0];
            CSR_POINT_Z:   cfg_ff.point[2]  <= csr_data[COORD_W-1:0];
            CSR_NORMAL_X:  cfg_ff.normal[0] <= csr_data[COORD_W-1:0];
            CSR_NORMAL_Y:  cfg_ff.normal[1] <= csr_data[COORD_W-1:0];
            CSR_NORMAL_Z:  cfg_ff.normal[2] <= csr_data[COORD_W-1:0];
            CSR_THRESHOLD: cfg_ff.threshold <= csr_data[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request payload, element 0 is x.
   // ---------------------------------------------------------------------
   assign ray.origin = {req_origin_z, req_origin_y, req_origin_x};
   assign ray.dir    = {req_dir_z, req_dir_y, req_dir_x};

   // Each stage holds its data while the next one is full and blocked, so
   // bubbles collapse and a new request enters whenever the first stage
   // can move.
   assign req_stall = !dot_in_ready;

   // num = (P - O) . N and den = D . N, exact
   rpi_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (dot_in_ready),
      .in_ray    (ray),
      .out_valid (dot_valid),
      .out_ready (cls_in_ready),
      .out_dot   (dot)
   );

   // magnitudes, parallel test, negative-t test, overflow test
   rpi_classify #(
      .FRAC_BITS (FRAC_BITS)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (dot_valid),
      .in_ready  (cls_in_ready),
      .in_dot    (dot),
      .out_valid (cls_valid),
      .out_ready (div_in_ready),
      .out_cls   (cls)
   );

   // t = |num| * 2^F / |den|, truncated
   rpi_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (div_in_ready),
      .in_cls    (cls),
      .out_valid (div_valid),
      .out_ready (out_open),
      .out_div   (div)
   );

   // ---------------------------------------------------------------------
   // Output register. A miss reports zero distance; an overflowing
   // quotient saturates to the largest positive value.
   // ---------------------------------------------------------------------
   assign out_open     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_open ? div_valid : rsp_valid_ff;

   always_comb begin
      priority if (!div.hit) begin
         distance_in = '0;
      end else if (div.sat) begin
         distance_in = DIST_MAX;
      end else begin
         distance_in = div.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open && div_valid) begin
         rsp_hit_ff      <= div.hit;
         rsp_distance_ff <= distance_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_distance_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // an empty output register means every stage can move
   `RPI_ASSERT_IMPL(a_empty_not_stalled, clock, reset, !rsp_valid_ff, !req_stall)
   // a finished quotient taken from the divider shows up as a response
   `RPI_ASSERT_NEXT(a_div_to_rsp, clock, reset, div_valid && out_open, rsp_valid_ff)
   // a miss never carries a distance
   `RPI_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, rsp_distance_ff == '0)

endmodule

>>> src/rpi_dot.sv
// ----------------------------------------------------------------------------
// rpi_dot
// Three stages: point minus origin, six products, then the two dot sums.
// ----------------------------------------------------------------------------
module rpi_dot (
   input  logic             clock,
   input  logic             reset,
   input  rpi_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpi_pkg::ray_type in_ray,
   output logic             out_valid,
   input  logic             out_ready,
   output rpi_pkg::dot_type out_dot
);
   import rpi_pkg::*;

   logic s1_valid_ff, s1_valid_in, s1_open;
   logic s2_valid_ff, s2_valid_in, s2_open;
   logic s3_valid_ff, s3_valid_in, s3_open;

   logic signed [DIFF_W-1:0]   diff_ff   [3];
   logic signed [COORD_W-1:0]  dir_ff    [3];
   logic signed [PROD_N_W-1:0] prod_n_ff [3];
   logic signed [PROD_D_W-1:0] prod_d_ff [3];
   logic signed [NUM_W-1:0]    num_ff;
   logic signed [DEN_W-1:0]    den_ff;

   // a stage takes new data when empty or when its contents move on
   assign s3_open = !s3_valid_ff || out_ready;
   assign s2_open = !s2_valid_ff || s3_open;
   assign s1_open = !s1_valid_ff || s2_open;
   assign in_ready = s1_open;

   assign s1_valid_in = s1_open ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_open ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= DIFF_W'($signed(cfg.point[i])) - DIFF_W'($signed(in_ray.origin[i]));
            dir_ff[i]  <= $signed(in_ray.dir[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_open && s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            prod_n_ff[i] <= diff_ff[i] * $signed(cfg.normal[i]);
            prod_d_ff[i] <= dir_ff[i] * $signed(cfg.normal[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_open && s2_valid_ff) begin
         num_ff <= NUM_W'(prod_n_ff[0]) + NUM_W'(prod_n_ff[1]) + NUM_W'(prod_n_ff[2]);
         den_ff <= DEN_W'(prod_d_ff[0]) + DEN_W'(prod_d_ff[1]) + DEN_W'(prod_d_ff[2]);
      end
   end

   assign out_valid   = s3_valid_ff;
   assign out_dot.num = num_ff;
   assign out_dot.den = den_ff;

endmodule

>>> src/rpi_classify.sv
// ----------------------------------------------------------------------------
// rpi_classify
// Two stages: magnitudes and signs, then the parallel, sign and overflow tests.
// ----------------------------------------------------------------------------
module rpi_classify #(
   parameter int FRAC_BITS = rpi_pkg::DEFAULT_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  rpi_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpi_pkg::dot_type in_dot,
   output logic             out_valid,
   input  logic             out_ready,
   output rpi_pkg::cls_type out_cls
);
   import rpi_pkg::*;

   localparam int SAT_SH = QUO_W - FRAC_BITS;
   localparam int SAT_W  = MAG_D_W + SAT_SH;
   localparam int CMP_W  = (SAT_W > MAG_N_W) ? SAT_W : MAG_N_W;
   localparam logic [MAG_D_W:0] HALF = (MAG_D_W + 1)'(1) << (FRAC_BITS - 1);

   logic s4_valid_ff, s4_valid_in, s4_open;
   logic s5_valid_ff, s5_valid_in, s5_open;

   logic [NUM_W-1:0]   num_abs;
   logic [DEN_W-1:0]   den_abs;
   logic [MAG_N_W-1:0] n_mag_ff;
   logic [MAG_D_W-1:0] d_mag_ff;
   logic               num_neg_ff;
   logic               den_neg_ff;

   logic [MAG_D_W:0]   rnd_sum;
   logic [MAG_D_W:0]   rounded;
   logic               parallel;
   logic               neg_t;
   logic               sat;
   cls_type            cls_ff;

   assign s5_open = !s5_valid_ff || out_ready;
   assign s4_open = !s4_valid_ff || s5_open;
   assign in_ready = s4_open;

   assign s4_valid_in = s4_open ? in_valid    : s4_valid_ff;
   assign s5_valid_in = s5_open ? s4_valid_ff : s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_comb begin
      num_abs = in_dot.num[NUM_W-1] ? NUM_W'(-in_dot.num) : NUM_W'(in_dot.num);
      den_abs = in_dot.den[DEN_W-1] ? DEN_W'(-in_dot.den) : DEN_W'(in_dot.den);
   end

   always_ff @(posedge clock) begin
      if (s4_open && in_valid) begin
         n_mag_ff   <= num_abs[MAG_N_W-1:0];
         d_mag_ff   <= den_abs[MAG_D_W-1:0];
         num_neg_ff <= in_dot.num[NUM_W-1];
         den_neg_ff <= in_dot.den[DEN_W-1];
      end
   end

   // round |den| half away from zero to the coordinate format
   always_comb begin
      rnd_sum  = {1'b0, d_mag_ff} + HALF;
      rounded  = rnd_sum >> FRAC_BITS;
      parallel = (d_mag_ff == '0) || (rounded < (MAG_D_W + 1)'(cfg.threshold));
      neg_t    = (n_mag_ff != '0) && (num_neg_ff != den_neg_ff);
      sat      = CMP_W'(n_mag_ff) >= (CMP_W'(d_mag_ff) << SAT_SH);
   end

   always_ff @(posedge clock) begin
      if (s5_open && s4_valid_ff) begin
         cls_ff.n_mag <= n_mag_ff;
         cls_ff.d_mag <= d_mag_ff;
         cls_ff.hit   <= !parallel && !neg_t;
         cls_ff.sat   <= sat;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_cls   = cls_ff;

endmodule

>>> src/rpi_divider.sv
// ----------------------------------------------------------------------------
// rpi_divider
// Restoring divider, one quotient bit per pipeline stage, most significant first.
// ----------------------------------------------------------------------------
module rpi_divider #(
   parameter int FRAC_BITS = rpi_pkg::DEFAULT_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpi_pkg::cls_type in_cls,
   output logic             out_valid,
   input  logic             out_ready,
   output rpi_pkg::div_type out_div
);
   import rpi_pkg::*;

   localparam int SHN   = MAG_N_W + FRAC_BITS;
   localparam int SHD   = MAG_D_W + QUO_W;
   localparam int REM_W = (SHN > SHD) ? SHN : SHD;

   logic               valid_ff   [QUO_W];
   logic               stage_open [QUO_W];
   logic [QUO_W-1:0]   quo_ff     [QUO_W];
   logic               hit_ff     [QUO_W];
   logic               sat_ff     [QUO_W];
   logic [REM_W-1:0]   rem_ff     [QUO_W-1];
   logic [MAG_D_W-1:0] d_ff       [QUO_W-1];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int BIT = QUO_W - 1 - k;

      logic               src_valid;
      logic [REM_W-1:0]   rem_src;
      logic [MAG_D_W-1:0] d_src;
      logic [QUO_W-1:0]   quo_src;
      logic               hit_src;
      logic               sat_src;
      logic [REM_W:0]     trial;
      logic               q_bit;
      logic               valid_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign rem_src   = REM_W'(in_cls.n_mag) << FRAC_BITS;
         assign d_src     = in_cls.d_mag;
         assign quo_src   = '0;
         assign hit_src   = in_cls.hit;
         assign sat_src   = in_cls.sat;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign d_src     = d_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign hit_src   = hit_ff[k-1];
         assign sat_src   = sat_ff[k-1];
      end

      if (k == QUO_W - 1) begin : g_last_open
         assign stage_open[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid_open
         assign stage_open[k] = !valid_ff[k] || stage_open[k+1];
      end

      assign trial    = {1'b0, rem_src} - ((REM_W + 1)'(d_src) << BIT);
      assign q_bit    = !trial[REM_W];
      assign valid_in = stage_open[k] ? src_valid : valid_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_open[k] && src_valid) begin
            quo_ff[k] <= quo_src | (QUO_W'(q_bit) << BIT);
            hit_ff[k] <= hit_src;
            sat_ff[k] <= sat_src;
         end
      end

      // the last stage needs neither remainder nor divisor
      if (k < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_open[k] && src_valid) begin
               rem_ff[k] <= q_bit ? trial[REM_W-1:0] : rem_src;
               d_ff[k]   <= d_src;
            end
         end
      end
   end

   assign in_ready    = stage_open[0];
   assign out_valid   = valid_ff[QUO_W-1];
   assign out_div.hit = hit_ff[QUO_W-1];
   assign out_div.sat = sat_ff[QUO_W-1];
   assign out_div.quo = quo_ff[QUO_W-1];

endmodule
